// ----- hdl/cat_text_stream_filter_defines.svh -----
// ---------------------------------------------------------------------------
// cat_text_stream_filter_defines.svh
// Assertion macros shared by the text filter modules.
// ---------------------------------------------------------------------------
`ifndef CAT_TEXT_STREAM_FILTER_DEFINES_SVH
`define CAT_TEXT_STREAM_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cts_pkg.sv -----
// ---------------------------------------------------------------------------
// cts_pkg
// Types, character codes and sizes shared by the text filter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int BCD_W         = 4 * NUMBER_DIGITS;
  // Slots of one result run: digits, tab, mark, final byte
  localparam int SLOT_COUNT    = NUMBER_DIGITS + 3;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);

  // Queue depth must be a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [BCD_W-1:0]  bcd_t;

  localparam slot_t SLOT_TAB  = slot_t'(NUMBER_DIGITS);
  localparam slot_t SLOT_MARK = slot_t'(NUMBER_DIGITS + 1);
  localparam slot_t SLOT_LAST = slot_t'(NUMBER_DIGITS + 2);

  localparam bcd_t BCD_ONE = bcd_t'(1);

  // Register indexes of the configuration port
  localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd0;
  localparam logic [2:0] REG_NUMBER_ALL       = 3'd1;
  localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
  localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
  localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

  // Character codes
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_QMARK    = 8'd63;
  localparam logic [7:0] CH_I        = 8'd73;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // One classified input byte; digits[0] is the most significant character
  typedef struct packed {
    logic                            num_en;
    logic [NUMBER_DIGITS-1:0][7:0]   digits;
    logic                            mark_en;
    logic [7:0]                      mark;
    logic [7:0]                      data;
  } item_t;

endpackage

`default_nettype wire

// ----- hdl/cat_text_stream_filter.sv -----
// ---------------------------------------------------------------------------
// cat_text_stream_filter
// Byte stream text filter with line numbering, blank squeezing and visible
// control characters.
// ---------------------------------------------------------------------------
// Input bytes arrive on the s_axis side, tuser marking the first byte of a
// new file; output bytes leave on m_axis with tlast on the final byte that
// one input byte produces. Bytes needing no expansion stream at one per cycle
// while the queue has room and m_axis is ready. A byte that expands to k
// output bytes (up to nine: six number digits, tab, a '$' or '^' mark, the
// byte itself) holds the emitter until its final byte leaves, sent one per
// cycle while m_axis is ready from the head of a four-entry item queue; the
// input keeps taking bytes until that queue fills. A squeezed blank line
// gives no output. Options are written through cfg_we/cfg_index/cfg_data
// while the stream is idle; indexes above 5 are ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module cat_text_stream_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tuser,   // [0] file_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast
);

  cts_pkg::cfg_t  cfg;
  cts_pkg::item_t push_item;
  cts_pkg::item_t head_item;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cts_pkg::REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= cfg_data;
        cts_pkg::REG_NUMBER_ALL:       cfg.number_all       <= cfg_data;
        cts_pkg::REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data;
        cts_pkg::REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data;
        cts_pkg::REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data;
        cts_pkg::REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data;
        default: ;
      endcase
    end
  end

  cts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .file_start (s_axis_tuser),
    .push       (push),
    .item       (push_item),
    .queue_full (queue_full)
  );

  cts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .rd_item (head_item),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  cts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_item),
    .empty     (queue_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/cts_front.sv -----
// ---------------------------------------------------------------------------
// cts_front
// Accepts input bytes, tracks line state and classifies each byte into the
// prefix, mark and final byte that the back end emits.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cat_text_stream_filter_defines.svh"

module cts_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cts_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            file_start,
  output logic                 push,
  output cts_pkg::item_t       item,
  input  wire logic            queue_full
);

  cts_pkg::bcd_t line_count, line_count_next;
  logic          after_newline, after_newline_next;
  logic [1:0]    blank_run, blank_run_next;

  cts_pkg::bcd_t lc_eff;
  cts_pkg::bcd_t lc_inc;
  logic          an_eff;
  logic [1:0]    br_eff;
  logic [1:0]    br_up;
  logic          is_nl;
  logic          drop;
  logic          number_it;
  logic          num_en;
  logic          accept;
  logic          zero_run;
  logic          all_nines;
  logic          carry;
  logic [3:0]    digit;
  logic [7:0]    c_mid;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // A start of file restarts the line state before the byte is handled
    lc_eff = file_start ? cts_pkg::BCD_ONE : line_count;
    an_eff = file_start ? 1'b1 : after_newline;
    br_eff = file_start ? 2'd0 : blank_run;
    is_nl  = (in_byte == cts_pkg::CH_NL);

    br_up = (br_eff < 2'd2) ? br_eff + 2'd1 : br_eff;
    if (cfg.squeeze_blank && an_eff && is_nl) begin
      blank_run_next = br_up;
      drop           = (br_up > 2'd1);
    end else begin
      blank_run_next = 2'd0;
      drop           = 1'b0;
    end

    number_it = cfg.number_nonblank ? !is_nl : cfg.number_all;
    num_en    = an_eff && number_it;

    // Saturating BCD increment
    all_nines = 1'b1;
    carry     = 1'b1;
    lc_inc    = lc_eff;
    for (int i = 0; i < cts_pkg::NUMBER_DIGITS; i++) begin
      digit = lc_eff[4*i +: 4];
      if (digit != 4'd9) begin
        all_nines = 1'b0;
      end
      if (carry) begin
        if (digit == 4'd9) begin
          lc_inc[4*i +: 4] = 4'd0;
        end else begin
          lc_inc[4*i +: 4] = digit + 4'd1;
          carry            = 1'b0;
        end
      end
    end
    if (all_nines) begin
      lc_inc = lc_eff;
    end

    // Right-justified digits with leading zeros shown as spaces
    zero_run = 1'b1;
    for (int i = 0; i < cts_pkg::NUMBER_DIGITS; i++) begin
      digit    = lc_eff[4*(cts_pkg::NUMBER_DIGITS-1-i) +: 4];
      zero_run = zero_run && (digit == 4'd0);
      item.digits[i] = (zero_run && (i != cts_pkg::NUMBER_DIGITS - 1)) ?
                       cts_pkg::CH_SPACE : cts_pkg::CH_ZERO + {4'd0, digit};
    end
    item.num_en = num_en;

    item.mark_en = 1'b0;
    item.mark    = cts_pkg::CH_CARET;
    c_mid        = in_byte;
    if (cfg.show_ends && is_nl) begin
      item.mark_en = 1'b1;
      item.mark    = cts_pkg::CH_DOLLAR;
    end
    if (cfg.show_tabs && (in_byte == cts_pkg::CH_TAB)) begin
      item.mark_en = 1'b1;
      c_mid        = cts_pkg::CH_I;
    end
    item.data = c_mid;
    if (cfg.show_nonprinting && ((c_mid < cts_pkg::CH_TAB) ||
        ((c_mid > cts_pkg::CH_NL) && (c_mid < cts_pkg::CH_SPACE)))) begin
      item.mark_en = 1'b1;
      item.data    = c_mid + cts_pkg::CTRL_OFFSET;
    end else if (cfg.show_nonprinting && (c_mid == cts_pkg::CH_DEL)) begin
      item.mark_en = 1'b1;
      item.data    = cts_pkg::CH_QMARK;
    end

    // A dropped blank line keeps the state as restarted
    if (drop) begin
      line_count_next    = lc_eff;
      after_newline_next = an_eff;
    end else begin
      line_count_next    = num_en ? lc_inc : lc_eff;
      after_newline_next = is_nl;
    end
  end

  assign push = accept && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= cts_pkg::BCD_ONE;
      after_newline <= 1'b1;
      blank_run     <= 2'd0;
    end else if (accept) begin
      line_count    <= line_count_next;
      after_newline <= after_newline_next;
      blank_run     <= blank_run_next;
    end
  end

  `CTS_ASSERT_NOW(a_drop_is_squeezed_nl, accept && drop, cfg.squeeze_blank && is_nl, "dropped a byte that is not a squeezed newline")
  `CTS_ASSERT_NEXT(a_drop_keeps_count, accept && drop, line_count == $past(lc_eff), "line count moved on a dropped line")

endmodule

`default_nettype wire

// ----- hdl/cts_queue.sv -----
// ---------------------------------------------------------------------------
// cts_queue
// Short register queue of classified items between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cat_text_stream_filter_defines.svh"

module cts_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cts_pkg::item_t  wr_item,
  input  wire logic            pop,
  output cts_pkg::item_t       rd_item,
  output logic                 full,
  output logic                 empty
);

  cts_pkg::item_t                  entries [cts_pkg::QUEUE_DEPTH];
  logic [cts_pkg::QPTR_W-1:0]      wr_ptr;
  logic [cts_pkg::QPTR_W-1:0]      rd_ptr;
  logic [cts_pkg::QCNT_W-1:0]      count, count_next;

  assign full    = (count == cts_pkg::QCNT_W'(cts_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  `CTS_ASSERT_NOW(a_no_overflow, push, !full, "transfer into a full queue")
  `CTS_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from an empty queue")

endmodule

`default_nettype wire

// ----- hdl/cts_back.sv -----
// ---------------------------------------------------------------------------
// cts_back
// Walks the head item slot by slot and emits one output byte per cycle
// through an output register while the output is ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cat_text_stream_filter_defines.svh"

module cts_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cts_pkg::item_t  head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  cts_pkg::slot_t slot, slot_next;
  logic           fresh;
  cts_pkg::slot_t cur;
  cts_pkg::slot_t first_slot;
  logic           emit;
  logic           is_last;
  logic [7:0]     byte_sel;

  assign emit = !empty && (!out_valid || out_ready);

  always_comb begin
    if (head.num_en) begin
      first_slot = '0;
    end else if (head.mark_en) begin
      first_slot = cts_pkg::SLOT_MARK;
    end else begin
      first_slot = cts_pkg::SLOT_LAST;
    end
    cur     = fresh ? first_slot : slot;
    is_last = (cur == cts_pkg::SLOT_LAST);

    byte_sel = head.data;
    if (cur == cts_pkg::SLOT_MARK) begin
      byte_sel = head.mark;
    end else if (cur == cts_pkg::SLOT_TAB) begin
      byte_sel = cts_pkg::CH_TAB;
    end else begin
      for (int i = 0; i < cts_pkg::NUMBER_DIGITS; i++) begin
        if (cur == cts_pkg::slot_t'(i)) begin
          byte_sel = head.digits[i];
        end
      end
    end

    // Skip the mark slot when the item has none
    if (cur == cts_pkg::SLOT_TAB) begin
      slot_next = head.mark_en ? cts_pkg::SLOT_MARK : cts_pkg::SLOT_LAST;
    end else if (cur == cts_pkg::SLOT_MARK) begin
      slot_next = cts_pkg::SLOT_LAST;
    end else begin
      slot_next = cur + 1'b1;
    end
  end

  assign pop = emit && is_last;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_sel;
      out_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fresh     <= 1'b1;
      slot      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        fresh <= is_last;
        slot  <= slot_next;
      end
    end
  end

  `CTS_ASSERT_NOW(a_slot_in_range, !fresh, slot != '0 && slot <= cts_pkg::SLOT_LAST, "slot pointer out of range")
  `CTS_ASSERT_NEXT(a_last_flag_matches_pop, emit, out_last == $past(pop), "last flag and pop disagree")

endmodule

`default_nettype wire

// ----- tb/sv/tb_cat_text_stream_filter.sv -----
// ---------------------------------------------------------------------------
// tb_cat_text_stream_filter
// Self-checking bench for the text stream filter: a predictor mirrors line
// numbering, blank squeezing and visible-character options, and every output
// transfer is compared against the oldest predicted byte.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_cat_text_stream_filter;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         DRAIN_CYCLES  = 40;
  localparam int         REPORT_MAX    = 10;
  localparam logic [2:0] REG_SPARE_LO  = 3'd6;
  localparam logic [2:0] REG_SPARE_HI  = 3'd7;
  localparam logic [7:0] CH_CR         = 8'd13;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } filter_byte_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       cfg_we        = 1'b0;
  logic [2:0] cfg_index     = '0;
  logic       cfg_data      = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;    // [7:0] in_byte
  logic       s_axis_tuser  = 1'b0;  // [0] file_start
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic       m_axis_tlast;

  // Predictor state
  cts_pkg::cfg_t filter_opts;
  cts_pkg::bcd_t line_bcd;
  logic          at_line_start;
  logic [1:0]    blank_lines;
  filter_byte_t  expected_bytes[$];
  filter_byte_t  oldest_byte;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_in       = 0;
  int bytes_out      = 0;
  int fail_count     = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  cat_text_stream_filter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Work out the bytes one accepted input byte produces and queue them
  function automatic void predict_filter_bytes(input logic [7:0] in_byte,
                                               input logic file_start);
    logic [7:0] c;
    logic       number_it;
    logic       leading;
    logic       all_nines;
    logic       carry;
    logic [3:0] d;
    int         i;
    c = in_byte;
    if (file_start) begin
      line_bcd      = cts_pkg::BCD_ONE;
      at_line_start = 1'b1;
      blank_lines   = '0;
    end
    if (filter_opts.squeeze_blank && at_line_start && c == cts_pkg::CH_NL) begin
      if (blank_lines < 2'd2) blank_lines++;
      // drop every blank line after the first of a run
      if (blank_lines > 2'd1) return;
    end else begin
      blank_lines = '0;
    end
    number_it = filter_opts.number_nonblank ? (c != cts_pkg::CH_NL) :
                                              filter_opts.number_all;
    if (at_line_start && number_it) begin
      leading = 1'b1;
      for (i = cts_pkg::NUMBER_DIGITS - 1; i >= 0; i--) begin
        d = line_bcd[4*i +: 4];
        if (d != 4'd0 || i == 0) leading = 1'b0;
        expected_bytes.push_back('{leading ? cts_pkg::CH_SPACE :
                                             cts_pkg::CH_ZERO + d, 1'b0});
      end
      expected_bytes.push_back('{cts_pkg::CH_TAB, 1'b0});
      // advance the decimal counter, holding at all nines
      all_nines = 1'b1;
      for (i = 0; i < cts_pkg::NUMBER_DIGITS; i++)
        if (line_bcd[4*i +: 4] != 4'd9) all_nines = 1'b0;
      if (!all_nines) begin
        carry = 1'b1;
        for (i = 0; i < cts_pkg::NUMBER_DIGITS; i++) begin
          if (carry) begin
            if (line_bcd[4*i +: 4] == 4'd9) begin
              line_bcd[4*i +: 4] = 4'd0;
            end else begin
              line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
    end
    if (filter_opts.show_ends && c == cts_pkg::CH_NL)
      expected_bytes.push_back('{cts_pkg::CH_DOLLAR, 1'b0});
    if (filter_opts.show_tabs && c == cts_pkg::CH_TAB) begin
      expected_bytes.push_back('{cts_pkg::CH_CARET, 1'b0});
      c = cts_pkg::CH_I;
    end
    if (filter_opts.show_nonprinting && (c < cts_pkg::CH_TAB ||
        (c > cts_pkg::CH_NL && c < cts_pkg::CH_SPACE))) begin
      expected_bytes.push_back('{cts_pkg::CH_CARET, 1'b0});
      c = c + cts_pkg::CTRL_OFFSET;
    end else if (filter_opts.show_nonprinting && c == cts_pkg::CH_DEL) begin
      expected_bytes.push_back('{cts_pkg::CH_CARET, 1'b0});
      c = cts_pkg::CH_QMARK;
    end
    expected_bytes.push_back('{c, 1'b1});
    at_line_start = (c == cts_pkg::CH_NL);
  endfunction

  // Predict on input transfers, then check output transfers at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_filter_bytes(s_axis_tdata, s_axis_tuser);
        bytes_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_out++;
        if (expected_bytes.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("ERROR: unexpected output byte %02h last %0b",
                     m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          oldest_byte = expected_bytes.pop_front();
          if (m_axis_tdata !== oldest_byte.out_byte || m_axis_tlast !== oldest_byte.last) begin
            if (fail_count < REPORT_MAX)
              $display("ERROR: output %0d: byte exp %02h got %02h, last exp %0b got %0b",
                       bytes_out, oldest_byte.out_byte, m_axis_tdata,
                       oldest_byte.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timed out with %0d bytes outstanding", expected_bytes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold until transfer
  task automatic send_byte(input logic [7:0] in_byte, input logic file_start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= in_byte;
    s_axis_tuser  <= file_start;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_text(input string txt, input logic mark_first);
    int i;
    for (i = 0; i < txt.len(); i++)
      send_byte(txt[i], mark_first && i == 0);
  endtask

  // Drop valid, let every predicted byte arrive, then allow for squeezed bytes
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all six options, plus both unused indexes which must be ignored
  task automatic apply_options(input cts_pkg::cfg_t value);
    cfg_we    <= 1'b1;
    cfg_index <= cts_pkg::REG_NUMBER_NONBLANK;
    cfg_data  <= value.number_nonblank;
    @(posedge clk);
    cfg_index <= cts_pkg::REG_NUMBER_ALL;
    cfg_data  <= value.number_all;
    @(posedge clk);
    cfg_index <= cts_pkg::REG_SQUEEZE_BLANK;
    cfg_data  <= value.squeeze_blank;
    @(posedge clk);
    cfg_index <= cts_pkg::REG_SHOW_ENDS;
    cfg_data  <= value.show_ends;
    @(posedge clk);
    cfg_index <= cts_pkg::REG_SHOW_TABS;
    cfg_data  <= value.show_tabs;
    @(posedge clk);
    cfg_index <= cts_pkg::REG_SHOW_NONPRINTING;
    cfg_data  <= value.show_nonprinting;
    @(posedge clk);
    cfg_index <= REG_SPARE_LO;
    cfg_data  <= 1'($urandom_range(1));
    @(posedge clk);
    cfg_index <= REG_SPARE_HI;
    cfg_data  <= 1'($urandom_range(1));
    @(posedge clk);
    cfg_we      <= 1'b0;
    filter_opts  = value;
    settings_used++;
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(cts_pkg::CH_DEL, 1'b0);
    send_byte(cts_pkg::CH_TAB, 1'b0);
    send_byte(cts_pkg::CH_NL, 1'b0);
    drain_stream();
  endtask

  task automatic test_numbering();
    apply_options('{number_nonblank: 1'b0, number_all: 1'b1, default: 1'b0});
    send_text("a\n\nb", 1'b0);
    // a new file mid-line restarts the count at one
    send_byte("c", 1'b1);
    drain_stream();
    apply_options('{number_nonblank: 1'b1, number_all: 1'b1, default: 1'b0});
    send_text("\n\nd\n", 1'b0);
    drain_stream();
  endtask

  task automatic test_squeeze();
    apply_options('{number_all: 1'b1, squeeze_blank: 1'b1, show_ends: 1'b1, default: 1'b0});
    send_text("\n\n\n\n", 1'b0);
    // a file start inside a blank run clears the run
    send_byte(cts_pkg::CH_NL, 1'b1);
    send_text("\ne\n", 1'b0);
    drain_stream();
  endtask

  task automatic test_visible();
    apply_options('{show_tabs: 1'b1, show_nonprinting: 1'b1, show_ends: 1'b1, default: 1'b0});
    send_byte(8'h00, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(cts_pkg::CH_TAB, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(cts_pkg::CH_DEL, 1'b0);
    send_byte(8'h9B, 1'b0);
    send_byte(cts_pkg::CH_NL, 1'b0);
    drain_stream();
    // tab and newline are never caret-escaped by the control option alone
    apply_options('{show_nonprinting: 1'b1, default: 1'b0});
    send_byte(cts_pkg::CH_TAB, 1'b0);
    send_byte(cts_pkg::CH_NL, 1'b0);
    drain_stream();
  endtask

  // Carry through 9 and 99 on the line counter
  task automatic test_line_count_carry();
    int i;
    apply_options('{number_all: 1'b1, default: 1'b0});
    for (i = 0; i < 101; i++) send_byte(cts_pkg::CH_NL, i == 0);
    drain_stream();
  endtask

  task automatic test_random_traffic(input cts_pkg::cfg_t value, input int idle_pct,
                                     input int stall_pct, input int count);
    int         i;
    int         pick;
    logic [7:0] in_byte;
    apply_options(value);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 30)      in_byte = cts_pkg::CH_NL;
      else if (pick < 40) in_byte = cts_pkg::CH_TAB;
      else if (pick < 50) in_byte = 8'($urandom_range(31));
      else if (pick < 55) in_byte = cts_pkg::CH_DEL;
      else if (pick < 65) in_byte = 8'($urandom_range(255, 128));
      else if (pick < 90) in_byte = 8'($urandom_range(126, 32));
      else                in_byte = 8'($urandom_range(255));
      send_byte(in_byte, $urandom_range(99) < 4);
    end
    drain_stream();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    filter_opts   = '0;
    line_bcd      = cts_pkg::BCD_ONE;
    at_line_start = 1'b1;
    blank_lines   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_bytes();
    test_numbering();
    test_squeeze();
    test_visible();
    test_line_count_carry();
    test_random_traffic('1, 0, 0, 17);
    test_random_traffic(cts_pkg::cfg_t'($urandom_range(63)), 54, 0, 17);
    test_random_traffic(cts_pkg::cfg_t'($urandom_range(63)), 0, 54, 17);
    test_random_traffic(cts_pkg::cfg_t'($urandom_range(63)), 17, 17, 17);

    if (expected_bytes.size() != 0) fail_count++;
    $display("Run covered %0d input and %0d output transfers over %0d option settings,",
             bytes_in, bytes_out, settings_used);
    $display("including line counts past 100 and sender/receiver stalls.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
